@@ rtl/core/mbps_pkg.sv @@
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;

    localparam int WIN_DEPTH = MAX_PATTERN - 1;
    localparam int IDX_W     = $clog2(MAX_PATTERN);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    localparam int LEN_W     = 5;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 6;
    localparam int OUT_OFS_W = 32;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // Register index, taken from paddr[5:3].
    localparam logic [2:0] REG_VAL_LO  = 3'd0;
    localparam logic [2:0] REG_VAL_HI  = 3'd1;
    localparam logic [2:0] REG_MASK_LO = 3'd2;
    localparam logic [2:0] REG_MASK_HI = 3'd3;
    localparam logic [2:0] REG_LENGTH  = 3'd4;

    typedef logic [7:0] byte_t;
    typedef logic [OFFSET_BITS-1:0] pos_t;

endpackage

@@ rtl/core/masked_byte_pattern_scanner_top.sv @@
`timescale 1ns / 1ps

// Masked byte pattern scanner.
// The input channel (in_valid/in_ready) carries one region byte per beat in
// data_byte, with last_byte set on the final byte of the region. The output
// channel (out_valid/out_ready) carries at most one result beat per region:
// found=1 with the start offset of the first match, or found=0 with offset 0
// on the last byte when the region held no match. Bytes after a match are
// consumed silently until the end of the region.
// The pattern (up to 16 value/mask byte pairs and a length) is written over
// the APB port at byte addresses 0, 8, 16, 24 and 32 while the block is idle.
// An accepted byte is held in an input register until the result register
// can take its outcome, then a single compare stage checks the newest bytes
// against all pattern positions in parallel and loads the result register.
// One byte is taken per cycle as long as the result register is empty or
// being drained; this compare stage sets the rate.
// When the receiver stalls with a result waiting, the input register holds
// its byte and in_ready drops once it is full.
// Reset clears the region state and the valid flags, sets the length to 1 and the other pattern registers to 0.
module masked_byte_pattern_scanner_top
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            last_byte,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [mbps_pkg::OUT_OFS_W-1:0]  match_offset,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbps_pkg::ADDR_W-1:0]     paddr,
    input  logic [mbps_pkg::CFG_W-1:0]      pwdata,
    output logic [mbps_pkg::CFG_W-1:0]      prdata,
    output logic                            pready
);
    import mbps_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0]  val_lo_reg, val_hi_reg, mask_lo_reg, mask_hi_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [2:0]        reg_sel;
    logic              cfg_write;

    // Input register
    logic              a_valid_reg, a_valid_next;
    byte_t             a_data_reg;
    logic              a_last_reg;
    logic              in_fire, a_fire;

    // Region state
    byte_t             win_reg [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;
    pos_t              pos_reg, pos_next;
    logic              reported_reg, reported_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [OUT_OFS_W-1:0] offset_reg, offset_next;

    // Compare stage
    logic [2*CFG_W-1:0] values_all, masks_all;
    byte_t             seq [MAX_PATTERN];
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  seq_idx [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] care_vec, ok_vec;
    logic              window_full;
    logic              hit, match, emit;
    pos_t              start_pos;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_lo_reg  <= '0;
            val_hi_reg  <= '0;
            mask_lo_reg <= '0;
            mask_hi_reg <= '0;
            length_reg  <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_VAL_LO:  val_lo_reg  <= pwdata;
                REG_VAL_HI:  val_hi_reg  <= pwdata;
                REG_MASK_LO: mask_lo_reg <= pwdata;
                REG_MASK_HI: mask_hi_reg <= pwdata;
                REG_LENGTH:  length_reg  <= pwdata[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_VAL_LO:  prdata = val_lo_reg;
            REG_VAL_HI:  prdata = val_hi_reg;
            REG_MASK_LO: prdata = mask_lo_reg;
            REG_MASK_HI: prdata = mask_hi_reg;
            REG_LENGTH:  prdata = CFG_W'(length_reg);
            default:     prdata = '0;
        endcase
    end

    // Handshakes
    assign a_fire   = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || a_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_fire)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_fire)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_data_reg <= data_byte;
            a_last_reg <= last_byte;
        end
    end

    // Out-of-range lengths are clamped into 1..MAX_PATTERN.
    always_comb
    begin
        if (length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (length_reg > LEN_W'(MAX_PATTERN))
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = length_reg;
        end
    end

    assign values_all = {val_hi_reg, val_lo_reg};
    assign masks_all  = {mask_hi_reg, mask_lo_reg};

    // seq[0] is the byte being processed, seq[j] the byte j positions older.
    // Pattern byte i lines up with seq[len - 1 - i].
    always_comb
    begin
        seq[0] = a_data_reg;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            seq[j] = win_reg[j-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            seq_idx[i]  = len_eff - LEN_W'(1) - LEN_W'(i);
            care_vec[i] = (LEN_W'(i) < len_eff) && (masks_all[8*i +: 8] != 8'h00);
            ok_vec[i]   = ((seq[seq_idx[i][IDX_W-1:0]] & masks_all[8*i +: 8] & BYTE_MASK)
                           == values_all[8*i +: 8]);
        end
    end

    assign window_full = LEN_W'(fill_reg) >= (len_eff - LEN_W'(1));
    assign hit         = window_full && (care_vec != '0) && ((ok_vec | ~care_vec) == '1);
    assign match       = !reported_reg && hit;
    assign emit        = match || (a_last_reg && !reported_reg);
    assign start_pos   = pos_reg - OFFSET_BITS'(len_eff - LEN_W'(1));

    // Region state update
    always_comb
    begin
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        reported_next = reported_reg;
        if (a_fire)
        begin
            if (a_last_reg)
            begin
                fill_next     = '0;
                pos_next      = '0;
                reported_next = 1'b0;
            end
            else
            begin
                if (fill_reg != FILL_W'(WIN_DEPTH))
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                pos_next = pos_reg + OFFSET_BITS'(1);
                if (match)
                begin
                    reported_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            pos_reg      <= '0;
            reported_reg <= 1'b0;
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
            if (a_fire)
            begin
                for (int k = 0; k < WIN_DEPTH; k++)
                begin
                    if (a_last_reg)
                    begin
                        win_reg[k] <= '0;
                    end
                    else if (k == 0)
                    begin
                        win_reg[k] <= a_data_reg;
                    end
                    else
                    begin
                        win_reg[k] <= win_reg[k-1];
                    end
                end
            end
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        offset_next    = offset_reg;
        if (a_fire && emit)
        begin
            out_valid_next = 1'b1;
            found_next     = match;
            offset_next    = match ? OUT_OFS_W'(start_pos) : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

    // Checks
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        a_fire && a_last_reg |=> (fill_reg == '0) && (pos_reg == '0) && !reported_reg)
        else $error("region state not cleared after the last beat");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> offset_reg == '0)
        else $error("not-found result carries a nonzero offset");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> a_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a waiting result");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WIN_DEPTH))
        else $error("window fill count out of range");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg && a_fire |=> !(out_valid_reg && found_reg && $rose(out_valid_reg)))
        else $error("second match reported within one region");

endmodule

@@ tb/sv/masked_byte_pattern_scanner_top_tb.sv @@
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_top_tb;

    import mbps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_IDLE    = 17;
    localparam int HOLD_CYCLES = 250;
    localparam int ITEM_COUNT  = 650;

    // Write to an index past the last register; the block must ignore it.
    localparam logic [2:0] REG_UNUSED = 3'd5;

    localparam int STYLE_MIXED    = 0;
    localparam int STYLE_NO_CARE  = 1;
    localparam int STYLE_ALL_ONES = 2;
    localparam int STYLE_ALL_ZERO = 3;

    typedef struct packed
    {
        logic                 found;
        logic [OUT_OFS_W-1:0] offset;
    } scan_result_t;

    class scan_scoreboard;
        byte_t            pat_value [MAX_PATTERN];
        byte_t            pat_mask  [MAX_PATTERN];
        logic [LEN_W-1:0] pat_length;
        byte_t            history   [WIN_DEPTH];
        pos_t             position;
        bit               reported;
        int               fill;
        scan_result_t     expected_q [$];
        int               mismatches;

        function new();
            int k;
            for (k = 0; k < MAX_PATTERN; k++)
            begin
                pat_value[k] = '0;
                pat_mask[k]  = '0;
            end
            pat_length       = LEN_W'(1);
            mismatches       = 0;
            clear_region();
        endfunction

        function void clear_region();
            int k;
            for (k = 0; k < WIN_DEPTH; k++)
                history[k] = '0;
            position = '0;
            reported = 0;
            fill     = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [CFG_W-1:0] value);
            int k;
            for (k = 0; k < 8; k++)
            begin
                case (index)
                    REG_VAL_LO:  pat_value[k]     = value[8*k +: 8];
                    REG_VAL_HI:  pat_value[8 + k] = value[8*k +: 8];
                    REG_MASK_LO: pat_mask[k]      = value[8*k +: 8];
                    REG_MASK_HI: pat_mask[8 + k]  = value[8*k +: 8];
                    REG_LENGTH:  pat_length       = value[LEN_W-1:0];
                    default:     ;
                endcase
            end
        endfunction

        // Bytes that follow a match take no part in the search.
        function void note_byte(byte_t data, bit is_last);
            int           span;
            int           k;
            bit           hit;
            bit           any_care;
            bit           live;
            byte_t        seen;
            scan_result_t res;
            live = !reported;
            if (live)
            begin
                if (pat_length == 0)
                    span = 1;
                else if (pat_length > MAX_PATTERN)
                    span = MAX_PATTERN;
                else
                    span = int'(pat_length);
                hit      = (fill >= span - 1);
                any_care = 0;
                for (k = 0; k < span && hit; k++)
                begin
                    if (pat_mask[k] != 0)
                    begin
                        any_care = 1;
                        if (k == span - 1)
                            seen = data;
                        else
                            seen = history[span - 2 - k];
                        if ((seen & pat_mask[k]) != pat_value[k])
                            hit = 0;
                    end
                end
                if (hit && any_care)
                begin
                    res.found  = 1'b1;
                    res.offset = position - pos_t'(span - 1);
                    reported   = 1;
                    expected_q.push_back(res);
                end
                else if (is_last)
                begin
                    res = '0;
                    expected_q.push_back(res);
                end
            end
            for (k = WIN_DEPTH - 1; k > 0; k--)
                history[k] = history[k - 1];
            history[0] = data;
            if (fill < WIN_DEPTH)
                fill++;
            position++;
            if (is_last)
                clear_region();
        endfunction

        function void check_result(logic got_found, logic [OUT_OFS_W-1:0] got_offset);
            scan_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none expected: found=%0b offset=%0d",
                             $realtime, got_found, got_offset);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.found !== got_found || want.offset !== got_offset)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result mismatch: expected found=%0b offset=%0d, %s",
                                 $realtime, want.found, want.offset,
                                 $sformatf("got found=%0b offset=%0d",
                                           got_found, got_offset));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           data_byte;
    logic                 last_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic                 found;
    logic [OUT_OFS_W-1:0] match_offset;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [CFG_W-1:0]     pwdata;
    logic [CFG_W-1:0]     prdata;
    logic                 pready;

    scan_scoreboard sb = new();

    byte_t            stim_value [MAX_PATTERN];
    byte_t            stim_mask  [MAX_PATTERN];
    logic [LEN_W-1:0] stim_len_code;
    int               stim_len;
    bit               tx_idle;
    bit               rx_idle;
    int               hold_requests = 0;
    int               hold_served   = 0;
    int               sent_items;
    int               cycle_count   = 0;

    masked_byte_pattern_scanner_top i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .match_offset (match_offset),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("masked_byte_pattern_scanner_top_tb: FAIL");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] index, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(index, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_pattern();
        logic [CFG_W-1:0] v_lo;
        logic [CFG_W-1:0] v_hi;
        logic [CFG_W-1:0] m_lo;
        logic [CFG_W-1:0] m_hi;
        int               k;
        for (k = 0; k < 8; k++)
        begin
            v_lo[8*k +: 8] = stim_value[k];
            v_hi[8*k +: 8] = stim_value[8 + k];
            m_lo[8*k +: 8] = stim_mask[k];
            m_hi[8*k +: 8] = stim_mask[8 + k];
        end
        apb_write(REG_VAL_LO, v_lo);
        apb_write(REG_VAL_HI, v_hi);
        apb_write(REG_MASK_LO, m_lo);
        apb_write(REG_MASK_HI, m_hi);
        apb_write(REG_LENGTH, CFG_W'(stim_len_code));
        if (stim_len_code == 0)
            stim_len = 1;
        else if (stim_len_code > MAX_PATTERN)
            stim_len = MAX_PATTERN;
        else
            stim_len = int'(stim_len_code);
    endtask

    task automatic clear_pattern();
        int k;
        for (k = 0; k < MAX_PATTERN; k++)
        begin
            stim_value[k] = '0;
            stim_mask[k]  = '0;
        end
    endtask

    // The block may still hold a skipped byte after the last result, so the
    // task waits on with the input idle before the pattern may change.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_byte(byte_t value, bit is_last);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(value, is_last);
        sent_items++;
    endtask

    // Sends up to eight bytes, lowest byte first, with the end mark on the final one.
    task automatic send_packed(int count, logic [63:0] bytes);
        int k;
        for (k = 0; k < count; k++)
            send_byte(bytes[8*k +: 8], k == count - 1);
    endtask

    task automatic send_region(int region_len, bit plant, bit spoil);
        byte_t bytes [$];
        byte_t b;
        byte_t m;
        int    k;
        int    slot;
        int    start_at;
        for (k = 0; k < region_len; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                b = byte_t'($urandom_range(0, 255));
            else
            begin
                slot = $urandom_range(0, stim_len - 1);
                b    = stim_value[slot];
            end
            bytes.push_back(b);
        end
        if (plant && region_len >= stim_len)
        begin
            start_at = $urandom_range(0, region_len - stim_len);
            for (k = 0; k < stim_len; k++)
                bytes[start_at + k] = stim_value[k]
                                      | (byte_t'($urandom_range(0, 255)) & ~stim_mask[k]);
            if (spoil)
            begin
                slot = $urandom_range(0, stim_len - 1);
                m    = stim_mask[slot];
                bytes[start_at + slot] = bytes[start_at + slot] ^ (m & (~m + 8'd1));
            end
        end
        for (k = 0; k < region_len; k++)
            send_byte(bytes[k], k == region_len - 1);
    endtask

    task automatic pick_pattern(int style);
        int k;
        int roll;
        for (k = 0; k < MAX_PATTERN; k++)
        begin
            roll = $urandom_range(0, 99);
            case (style)
                STYLE_NO_CARE:
                begin
                    stim_mask[k]  = '0;
                    stim_value[k] = byte_t'($urandom_range(0, 255));
                end
                STYLE_ALL_ONES:
                begin
                    stim_mask[k]  = 8'hFF;
                    stim_value[k] = 8'hFF;
                end
                STYLE_ALL_ZERO:
                begin
                    stim_mask[k]  = 8'hFF;
                    stim_value[k] = 8'h00;
                end
                default:
                begin
                    if (roll < 25)
                        stim_mask[k] = '0;
                    else if (roll < 65)
                        stim_mask[k] = 8'hFF;
                    else
                        stim_mask[k] = byte_t'($urandom_range(1, 254));
                    stim_value[k] = byte_t'($urandom_range(0, 255));
                    // Now and then a value bit falls outside its mask.
                    if ($urandom_range(0, 19) != 0)
                        stim_value[k] = stim_value[k] & stim_mask[k];
                end
            endcase
        end
        roll = $urandom_range(0, 9);
        if (style == STYLE_ALL_ONES)
            stim_len_code = LEN_W'(31);
        else if (style == STYLE_ALL_ZERO)
            stim_len_code = LEN_W'(16);
        else if (roll == 0)
            stim_len_code = LEN_W'(0);
        else if (roll == 1)
            stim_len_code = LEN_W'(16);
        else if (roll == 2)
            stim_len_code = LEN_W'(17);
        else if (roll == 3)
            stim_len_code = LEN_W'(31);
        else
            stim_len_code = LEN_W'($urandom_range(1, 16));
        load_pattern();
    endtask

    // Receiver: draws a stall before each result beat, with runs of no stalls.
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        rx_idle   = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_served != hold_requests)
            begin
                stall       = HOLD_CYCLES;
                hold_served = hold_requests;
            end
            else
                stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(found, match_offset);
            if ($urandom_range(0, 7) == 0)
                rx_idle = !rx_idle;
        end
    end

    initial
    begin : stimulus
        int phase;
        int r;
        int roll;
        int region_len;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = '0;
        last_byte   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle     = 1'b1;
        sent_items  = 0;
        clear_pattern();
        stim_len_code = LEN_W'(1);
        stim_len      = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pattern has no cared byte, so regions end without a match.
        send_packed(2, 64'hFF_00);
        send_packed(1, 64'hA5);
        drain_results();

        // Three bytes with a wildcard in the middle.
        stim_value[0] = 8'h12;
        stim_mask[0]  = 8'hFF;
        stim_value[2] = 8'h34;
        stim_mask[2]  = 8'hFF;
        stim_len_code = LEN_W'(3);
        load_pattern();
        send_packed(3, 64'h34_77_12);
        send_packed(2, 64'h99_12);
        // Match at offset 1; the bytes after it, end mark included, are skipped.
        send_packed(7, 64'h34_11_12_34_00_12_55);
        send_packed(3, 64'h35_11_12);
        drain_results();

        // A length of zero acts as one; the extra register write is dropped.
        clear_pattern();
        stim_value[0] = 8'h80;
        stim_mask[0]  = 8'h80;
        stim_len_code = LEN_W'(0);
        load_pattern();
        apb_write(REG_UNUSED, '1);
        send_packed(2, 64'hFF_7F);
        drain_results();

        // Trailing wildcards must still fit inside the region.
        clear_pattern();
        stim_value[0] = 8'h12;
        stim_mask[0]  = 8'hFF;
        stim_value[1] = 8'h34;
        stim_mask[1]  = 8'hFF;
        stim_len_code = LEN_W'(4);
        load_pattern();
        send_packed(3, 64'h00_34_12);
        drain_results();

        // A value bit outside its mask can never match.
        clear_pattern();
        stim_value[0] = 8'hF0;
        stim_mask[0]  = 8'h0F;
        stim_len_code = LEN_W'(1);
        load_pattern();
        send_packed(1, 64'hF0);

        phase = 0;
        while (sent_items < ITEM_COUNT || phase < 4)
        begin
            drain_results();
            if (phase == 0)
                pick_pattern(STYLE_ALL_ONES);
            else if (phase == 1)
                pick_pattern(STYLE_NO_CARE);
            else if (phase == 2)
                pick_pattern(STYLE_ALL_ZERO);
            else
                pick_pattern(STYLE_MIXED);
            for (r = 0; r < 8; r++)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) < 7)
                    region_len = $urandom_range(1, stim_len + 6);
                else
                    region_len = $urandom_range(1, 60);
                roll = $urandom_range(0, 99);
                send_region(region_len, roll < 65, roll >= 65 && roll < 80);
                if ($urandom_range(0, 9) == 0)
                    drain_results();
            end
            if (phase == 3)
            begin
                // Receiver holds off while short regions keep coming, so the
                // result and input registers fill and the input stalls.
                hold_requests++;
                tx_idle = 1'b0;
                for (r = 0; r < 40; r++)
                    send_region($urandom_range(1, 2), 1'b0, 1'b0);
            end
            phase++;
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("masked_byte_pattern_scanner_top_tb: PASS");
        else
            $display("masked_byte_pattern_scanner_top_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mbps_pkg.sv
rtl/core/masked_byte_pattern_scanner_top.sv
tb/sv/masked_byte_pattern_scanner_top_tb.sv
